FILE: src/irpt_pkg.sv
// Shared types and constants for the IR pulse-train feature extractor.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
package irpt_pkg;

    localparam int MAX_SEGMENTS_DEF = 1024;

    localparam int DUR_W   = 16;
    localparam int TICK_W  = 15;
    localparam int CNT_W   = 11;
    localparam int TOTAL_W = 26;
    localparam int PULSE_W = 10;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 128;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_LEAD_TRIM  = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_TAIL_TRIM  = 2'd2;

    localparam logic [DUR_W-1:0] LEAD_TRIM_RST = 16'd15000;
    localparam logic [DUR_W-1:0] TAIL_TRIM_RST = 16'd10000;

    typedef struct packed {
        logic             active_low;
        logic [DUR_W-1:0] lead_trim;
        logic [DUR_W-1:0] tail_trim;
    } t_cfg;

    typedef struct packed {
        logic             present;
        logic             level;
        logic             over_lead;
        logic [DUR_W-1:0] dur;
    } t_seg;

    typedef struct packed {
        logic               dropped;
        logic               head_trim;
        logic [DUR_W-1:0]   seg0;
        logic [DUR_W-1:0]   second;
        logic [DUR_W-1:0]   third;
        logic [DUR_W-1:0]   held;
        logic [DUR_W-1:0]   last_acc;
        logic [TOTAL_W-1:0] total;
        logic [PULSE_W-1:0] pulses;
        logic [DUR_W-1:0]   mn;
        logic [DUR_W-1:0]   mx;
    } t_frame;

endpackage

FILE: src/irpt_lane.sv
// One half-symbol lane: tick-to-microsecond conversion and lead-threshold compare.
// Depends on irpt_pkg.
`timescale 1ns / 1ps
module irpt_lane
    import irpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_level,
    input  logic [TICK_W-1:0] i_ticks,
    input  logic [DUR_W-1:0]  i_lead_trim,
    output t_seg              o_seg
);

    t_seg r_seg;
    t_seg n_seg;

    always_comb begin
        n_seg.present   = |i_ticks;
        n_seg.level     = i_level;
        n_seg.dur       = {i_ticks, 1'b0};
        n_seg.over_lead = {i_ticks, 1'b0} > i_lead_trim;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

FILE: src/irpt_merge.sv
// Merge stage: folds both lane segments of a symbol into the frame state and
// snapshots the state at frame end. Depends on irpt_pkg.
`timescale 1ns / 1ps
module irpt_merge
    import irpt_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int SEG_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic             i_end,
    input  t_seg             i_seg_a,
    input  t_seg             i_seg_b,
    input  t_cfg             i_cfg,
    input  logic             i_out_free,
    output logic             o_free,
    output logic             o_snap_vld,
    output t_frame           o_snap,
    output logic [SEG_W-1:0] o_snap_n
);

    localparam int DROP_LIM = (MAX_SEGMENTS + 1) / 2;
    localparam int TALLY_W  = $clog2(DROP_LIM + 2);
    localparam logic [TALLY_W-1:0] TALLY_SAT = TALLY_W'(DROP_LIM + 1);
    localparam logic [SEG_W-1:0]   SEG_MAX   = SEG_W'(MAX_SEGMENTS);

    t_frame             r_frame;
    logic [SEG_W-1:0]   r_cnt;
    logic [TALLY_W-1:0] r_tally;
    t_frame             r_snap;
    logic [SEG_W-1:0]   r_snap_n;
    logic               r_snap_vld;

    t_frame             n_frame;
    logic [SEG_W-1:0]   n_cnt;
    logic [TALLY_W-1:0] n_tally;
    t_frame             f_mid;
    logic [SEG_W-1:0]   cnt_mid;
    logic               go;
    logic               snap_free;

    function automatic t_frame add_seg(t_frame f, logic [SEG_W-1:0] i, t_seg s, t_cfg c);
        t_frame r;
        r = f;
        if (i == '0) begin
            r.seg0      = s.dur;
            r.head_trim = s.over_lead || (c.active_low && s.level);
        end else begin
            if (i >= SEG_W'(2)) begin
                r.total    = f.total + TOTAL_W'(f.held);
                r.last_acc = f.held;
                if (i[0] != f.head_trim) begin
                    r.pulses = f.pulses + 1'b1;
                    if (!(i == SEG_W'(2) && f.head_trim)) begin
                        if (f.mn == '0 || f.held < f.mn) r.mn = f.held;
                        if (f.held > f.mx) r.mx = f.held;
                    end
                end
            end
            if (i == SEG_W'(1)) r.second = s.dur;
            if (i == SEG_W'(2)) r.third = s.dur;
        end
        r.held = s.dur;
        return r;
    endfunction

    assign snap_free = !r_snap_vld || i_out_free;
    assign go        = i_vld && (snap_free || !i_end);
    assign o_free    = !i_vld || go;

    always_comb begin
        f_mid   = r_frame;
        cnt_mid = r_cnt;
        if (i_seg_a.present && r_cnt != SEG_MAX) begin
            f_mid   = add_seg(r_frame, r_cnt, i_seg_a, i_cfg);
            cnt_mid = r_cnt + 1'b1;
        end
        n_frame = f_mid;
        n_cnt   = cnt_mid;
        if (i_seg_b.present && cnt_mid != SEG_MAX) begin
            n_frame = add_seg(f_mid, cnt_mid, i_seg_b, i_cfg);
            n_cnt   = cnt_mid + 1'b1;
        end
        n_tally = (r_tally == TALLY_SAT) ? r_tally : r_tally + 1'b1;
        n_frame.dropped = n_tally > TALLY_W'(DROP_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= '0;
            r_cnt      <= '0;
            r_tally    <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            if (go) begin
                if (i_end) begin
                    r_frame <= '0;
                    r_cnt   <= '0;
                    r_tally <= '0;
                end else begin
                    r_frame <= n_frame;
                    r_cnt   <= n_cnt;
                    r_tally <= n_tally;
                end
            end
            if (go && i_end) begin
                r_snap_vld <= 1'b1;
            end else if (r_snap_vld && i_out_free) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && i_end) begin
            r_snap   <= n_frame;
            r_snap_n <= n_cnt;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;
    assign o_snap_n   = r_snap_n;

endmodule

FILE: src/irpt_summary.sv
// Summary stage: applies tail trim to a frame snapshot and registers the result.
// Depends on irpt_pkg.
`timescale 1ns / 1ps
module irpt_summary
    import irpt_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int SEG_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_snap_vld,
    input  t_frame           i_snap,
    input  logic [SEG_W-1:0] i_snap_n,
    input  logic [DUR_W-1:0] i_tail_trim,
    input  logic             i_m_tready,
    output logic             o_free,
    output logic             o_m_tvalid,
    output logic             o_m_tuser,
    output logic [OUT_W-1:0] o_m_tdata
);

    logic             r_vld;
    logic             r_dropped;
    logic [OUT_W-1:0] r_data;

    logic [OUT_W-1:0]   n_data;
    logic               start;
    logic               trim_tail;
    logic               keep;
    logic [SEG_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
    logic [PULSE_W-1:0] pulses;
    logic [DUR_W-1:0]   mn;
    logic [DUR_W-1:0]   mx;
    logic [DUR_W-1:0]   lp;
    logic [DUR_W-1:0]   ls;
    logic [DUR_W-1:0]   lg;
    logic               load;

    assign o_free = !r_vld || i_m_tready;
    assign load   = i_snap_vld && o_free;

    always_comb begin
        start     = i_snap.head_trim;
        trim_tail = ((i_snap_n - SEG_W'(start)) >= SEG_W'(2)) && (i_snap.held > i_tail_trim);
        keep      = !trim_tail;
        count     = i_snap_n - SEG_W'(start) - SEG_W'(trim_tail);
        total     = i_snap.total + (start ? '0 : TOTAL_W'(i_snap.seg0))
                    + (keep ? TOTAL_W'(i_snap.held) : '0);
        pulses    = i_snap.pulses + PULSE_W'(!start);
        mn        = i_snap.mn;
        mx        = i_snap.mx;
        if (keep && (i_snap_n[0] != start)) begin
            pulses = pulses + 1'b1;
            if (!(i_snap_n == SEG_W'(2) && start)) begin
                if (mn == '0 || i_snap.held < mn) mn = i_snap.held;
                if (i_snap.held > mx) mx = i_snap.held;
            end
        end
        lp = start ? i_snap.second : i_snap.seg0;
        ls = (count >= SEG_W'(2)) ? (start ? i_snap.third : i_snap.second) : '0;
        if (keep) begin
            lg = i_snap.held;
        end else if (i_snap_n >= SEG_W'(3)) begin
            lg = i_snap.last_acc;
        end else begin
            lg = i_snap.seg0;
        end

        n_data = '0;
        if (i_snap.dropped || i_snap_n == '0) begin
            n_data = '0;
        end else if (i_snap_n == SEG_W'(1)) begin
            n_data[10:0]  = CNT_W'(1);
            n_data[36:11] = TOTAL_W'(i_snap.seg0);
            n_data[52:37] = i_snap.seg0;
            n_data[84:69] = i_snap.seg0;
            n_data[94:85] = PULSE_W'(1);
        end else begin
            n_data[10:0]    = CNT_W'(count);
            n_data[36:11]   = total;
            n_data[52:37]   = lp;
            n_data[68:53]   = ls;
            n_data[84:69]   = lg;
            n_data[94:85]   = pulses;
            n_data[110:95]  = mn;
            n_data[126:111] = mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data    <= n_data;
            r_dropped <= i_snap.dropped;
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tuser  = r_dropped;
    assign o_m_tdata  = r_data;

endmodule

FILE: src/ir_pulse_train_features.sv
// Top level of the IR pulse-train feature extractor: config registers, two
// half-symbol lanes, merge stage and summary stage. Depends on irpt_pkg and all src modules.
//
// Channel   Dir  Signals                        Contents
// s         in   i_s_tvalid/o_s_tready/tdata   one captured symbol, tlast = frame end
// m         out  o_m_tvalid/i_m_tready/tdata   one frame summary, tuser = dropped
// cfg       in   i_cfg_we/addr/wdata           active_low, lead_trim_us, tail_trim_us
//
// One symbol per cycle sustained while o_s_tready is high. A frame-end symbol's summary
// passes in turn through the lane register at the transfer, merge snapshot, summary register.
// Synchronous active-low reset clears frame state and loads register defaults.
// An output stall fills the snapshot stage; input is held only once a frame-end
// symbol finds both snapshot and output registers occupied and i_m_tready low.
`timescale 1ns / 1ps
module ir_pulse_train_features
    import irpt_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // first_level[0], first_ticks[15:1], second_level[16], second_ticks[31:17]
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // kept segments[10:0], total time[36:11], header mark[52:37],
    // header gap[68:53], closing gap[84:69], mark count[94:85],
    // shortest mark[110:95], longest mark[126:111], zero pad[127]
    output logic [OUT_W-1:0]  o_m_tdata,
    // dropped[0]
    output logic              o_m_tuser,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [DUR_W-1:0]  i_cfg_wdata
);

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    t_cfg             r_cfg;
    logic             r_l_vld;
    logic             r_l_end;

    t_seg             seg_a;
    t_seg             seg_b;
    logic             lane_en;
    logic             merge_free;
    logic             out_free;
    logic             snap_vld;
    t_frame           snap;
    logic [SEG_W-1:0] snap_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low <= 1'b1;
            r_cfg.lead_trim  <= LEAD_TRIM_RST;
            r_cfg.tail_trim  <= TAIL_TRIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ACTIVE_LOW: r_cfg.active_low <= i_cfg_wdata[0];
                CFG_LEAD_TRIM:  r_cfg.lead_trim  <= i_cfg_wdata;
                CFG_TAIL_TRIM:  r_cfg.tail_trim  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = merge_free;
    assign lane_en    = i_s_tvalid && merge_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else if (merge_free) begin
            r_l_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_en) begin
            r_l_end <= i_s_tlast;
        end
    end

    irpt_lane u_lane_a (
        .i_clk       (i_clk),
        .i_en        (lane_en),
        .i_level     (i_s_tdata[0]),
        .i_ticks     (i_s_tdata[15:1]),
        .i_lead_trim (r_cfg.lead_trim),
        .o_seg       (seg_a)
    );

    irpt_lane u_lane_b (
        .i_clk       (i_clk),
        .i_en        (lane_en),
        .i_level     (i_s_tdata[16]),
        .i_ticks     (i_s_tdata[31:17]),
        .i_lead_trim (r_cfg.lead_trim),
        .o_seg       (seg_b)
    );

    irpt_merge #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SEG_W        (SEG_W)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_l_vld),
        .i_end      (r_l_end),
        .i_seg_a    (seg_a),
        .i_seg_b    (seg_b),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_free     (merge_free),
        .o_snap_vld (snap_vld),
        .o_snap     (snap),
        .o_snap_n   (snap_n)
    );

    irpt_summary #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SEG_W        (SEG_W)
    ) u_summary (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_vld  (snap_vld),
        .i_snap      (snap),
        .i_snap_n    (snap_n),
        .i_tail_trim (r_cfg.tail_trim),
        .i_m_tready  (i_m_tready),
        .o_free      (out_free),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
